// ===== design/c2w_pkg.sv =====
// Shared types, constants and a helper function for the CO2 sensor wake controller.
package c2w_pkg;

    typedef enum logic [1:0] {
        CMD_LEARN  = 2'd0,
        CMD_RESET  = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_SENSOR = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_SLEEP      = 3'd0,
        ACT_LEARN      = 3'd1,
        ACT_MEASURE    = 3'd2,
        ACT_CALIBRATE  = 3'd3,
        ACT_REPORT     = 3'd4,
        ACT_LOW_ENERGY = 3'd5,
        ACT_TIMEOUT    = 3'd6
    } action_t;

    typedef enum logic [2:0] {
        REG_SLEEP_PERIOD     = 3'd0,
        REG_CYCLE_MIN        = 3'd1,
        REG_CYCLE_MAX        = 3'd2,
        REG_LOW_CHARGE_LIMIT = 3'd3,
        REG_CLEAN_LEVEL      = 3'd4,
        REG_SUPPLY_MODE      = 3'd5
    } reg_idx_t;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [15:0] DEFAULT_INTERVAL    = 16'd600;
    localparam logic [15:0] INTERVAL_ALL_ONES   = 16'hFFFF;
    localparam logic [15:0] DEFAULT_CALIB_WAKES = 16'd1008;
    localparam logic [11:0] MAX_LEVEL           = 12'd2550;
    localparam logic [9:0]  MIN_CO2_RESET       = 10'd1000;
    localparam logic [15:0] SENSOR_WAIT         = 16'd3;
    localparam logic [7:0]  STATUS_DATA         = 8'h0A;
    localparam logic [7:0]  STATUS_CALIB        = 8'h0F;
    localparam logic [7:0]  CYCLE_ALL_ONES      = 8'hFF;
    localparam logic [7:0]  CO2_SATURATED       = 8'hFF;

    localparam logic [1:0]  MODE_OFF      = 2'd0;
    localparam logic [1:0]  MODE_FOLLOW   = 2'd1;
    localparam logic [1:0]  MODE_ON       = 2'd2;
    localparam logic [1:0]  MODE_RESERVED = 2'd3;

    localparam logic [15:0] RST_SLEEP_PERIOD     = 16'd600;
    localparam logic [7:0]  RST_CYCLE_MIN        = 8'd255;
    localparam logic [7:0]  RST_CYCLE_MAX        = 8'd255;
    localparam logic [7:0]  RST_LOW_CHARGE_LIMIT = 8'd1;
    localparam logic [11:0] RST_CLEAN_LEVEL      = 12'd450;
    localparam logic [1:0]  RST_SUPPLY_MODE      = 2'd2;

    typedef struct packed {
        logic [15:0] sleep_period;
        logic [7:0]  cycle_min;
        logic [7:0]  cycle_max;
        logic [7:0]  low_charge_limit;
        logic [11:0] clean_level;
        logic [1:0]  supply_mode;
    } cfg_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        button_pressed;
        logic [7:0]  charge_level;
        logic [15:0] co2_ppm;
        logic [7:0]  temperature_code;
    } item_t;

    typedef struct packed {
        action_t     action;
        logic [15:0] sleep_seconds;
        logic        wake_on_sensor;
        logic        supply_off;
        logic        report_valid;
        logic [7:0]  charge_byte;
        logic [7:0]  co2_byte;
        logic [7:0]  temperature_byte;
        logic [7:0]  status_byte;
        logic [15:0] calib_min_level;
        logic [11:0] calib_clean_level;
    } result_t;

    // Division by ten through a reciprocal; exact for inputs up to 2559.
    function automatic logic [7:0] div10(input logic [11:0] x);
        logic [23:0] p;
        p = 24'(x) * 24'd3277;
        return p[22:15];
    endfunction

endpackage

// ===== design/c2w_core.sv =====
// Wake event decision logic and the node state that it keeps between items.
module c2w_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  c2w_pkg::item_t   item,
    input  c2w_pkg::cfg_t    cfg,
    output c2w_pkg::result_t res
);

    logic        measuring_reg, measuring_next;
    logic [15:0] wake_count_reg, wake_count_next;
    logic [9:0]  min_co2_reg, min_co2_next;
    logic        mark_reg, mark_next;
    logic [7:0]  stored_charge_reg, stored_charge_next;
    logic [7:0]  seen_a_reg, seen_a_next;
    logic [7:0]  seen_b_reg, seen_b_next;

    logic [15:0] interval;
    logic [15:0] calib_wakes;
    logic [11:0] clean;
    logic        mode_off;
    logic        mode_follow;
    logic        changed;
    logic [15:0] wc_base;
    logic [15:0] wc_inc;
    logic        check_en;
    logic        low;
    logic        calib;

    always_comb begin
        interval = (cfg.sleep_period == 16'd0 ||
                    cfg.sleep_period == c2w_pkg::INTERVAL_ALL_ONES)
                   ? c2w_pkg::DEFAULT_INTERVAL : cfg.sleep_period;
        calib_wakes = (cfg.cycle_min == c2w_pkg::CYCLE_ALL_ONES &&
                       cfg.cycle_max == c2w_pkg::CYCLE_ALL_ONES)
                      ? c2w_pkg::DEFAULT_CALIB_WAKES
                      : 16'(cfg.cycle_min) * 16'(cfg.cycle_max);
        clean = (cfg.clean_level > c2w_pkg::MAX_LEVEL) ? c2w_pkg::MAX_LEVEL : cfg.clean_level;
        mode_off    = (cfg.supply_mode == c2w_pkg::MODE_OFF);
        mode_follow = (cfg.supply_mode == c2w_pkg::MODE_FOLLOW);

        changed  = (seen_a_reg != cfg.cycle_min) || (seen_b_reg != cfg.cycle_max);
        wc_base  = changed ? 16'd0 : wake_count_reg;
        wc_inc   = wc_base + 16'd1;
        check_en = !mode_off || (cfg.low_charge_limit != 8'd0);
        low      = check_en && (item.charge_level <= cfg.low_charge_limit);
        calib    = !low && (((cfg.cycle_min != 8'd0) && (cfg.cycle_max != 8'd0) &&
                             (wc_inc >= calib_wakes)) || item.button_pressed);

        measuring_next     = measuring_reg;
        wake_count_next    = wake_count_reg;
        min_co2_next       = min_co2_reg;
        mark_next          = mark_reg;
        stored_charge_next = stored_charge_reg;
        seen_a_next        = seen_a_reg;
        seen_b_next        = seen_b_reg;

        res = '0;
        res.action = c2w_pkg::ACT_SLEEP;

        unique case (item.cmd)
            c2w_pkg::CMD_LEARN: begin
                res.action = item.button_pressed ? c2w_pkg::ACT_LEARN : c2w_pkg::ACT_SLEEP;
            end
            c2w_pkg::CMD_RESET: begin
                measuring_next     = 1'b0;
                wake_count_next    = 16'd0;
                min_co2_next       = c2w_pkg::MIN_CO2_RESET;
                mark_next          = 1'b0;
                stored_charge_next = 8'd0;
                seen_a_next        = 8'd0;
                seen_b_next        = 8'd0;
                res.sleep_seconds  = interval;
            end
            c2w_pkg::CMD_TICK: begin
                seen_a_next = cfg.cycle_min;
                seen_b_next = cfg.cycle_max;
                if (measuring_reg) begin
                    wake_count_next   = wc_base;
                    measuring_next    = 1'b0;
                    res.action        = c2w_pkg::ACT_TIMEOUT;
                    res.sleep_seconds = interval;
                end else begin
                    stored_charge_next = item.charge_level;
                    wake_count_next    = wc_inc;
                    if (check_en) begin
                        mark_next = low && (mark_reg || mode_follow);
                    end
                    if (low) begin
                        res.action        = c2w_pkg::ACT_LOW_ENERGY;
                        res.sleep_seconds = interval;
                    end else if (calib) begin
                        wake_count_next       = 16'd0;
                        min_co2_next          = c2w_pkg::MIN_CO2_RESET;
                        res.action            = c2w_pkg::ACT_CALIBRATE;
                        res.report_valid      = 1'b1;
                        res.calib_min_level   = 16'(min_co2_reg);
                        res.calib_clean_level = clean;
                        res.charge_byte       = item.charge_level;
                        res.co2_byte          = c2w_pkg::div10(12'(min_co2_reg));
                        res.status_byte       = c2w_pkg::STATUS_CALIB;
                    end else begin
                        measuring_next     = 1'b1;
                        res.action         = c2w_pkg::ACT_MEASURE;
                        res.sleep_seconds  = c2w_pkg::SENSOR_WAIT;
                        res.wake_on_sensor = 1'b1;
                    end
                end
            end
            c2w_pkg::CMD_SENSOR: begin
                if ((item.co2_ppm < 16'(min_co2_reg)) && (item.co2_ppm != 16'd0)) begin
                    min_co2_next = item.co2_ppm[9:0];
                end
                measuring_next       = 1'b0;
                res.action           = c2w_pkg::ACT_REPORT;
                res.report_valid     = 1'b1;
                res.charge_byte      = stored_charge_reg;
                res.co2_byte         = (item.co2_ppm > 16'(c2w_pkg::MAX_LEVEL))
                                       ? c2w_pkg::CO2_SATURATED
                                       : c2w_pkg::div10(item.co2_ppm[11:0]);
                res.temperature_byte = item.temperature_code;
                res.status_byte      = c2w_pkg::STATUS_DATA;
                res.sleep_seconds    = interval;
            end
            default: begin
                res.action = c2w_pkg::ACT_SLEEP;
            end
        endcase

        res.supply_off = mode_off || mark_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            measuring_reg     <= 1'b0;
            wake_count_reg    <= 16'd0;
            min_co2_reg       <= c2w_pkg::MIN_CO2_RESET;
            mark_reg          <= 1'b0;
            stored_charge_reg <= 8'd0;
            seen_a_reg        <= 8'd0;
            seen_b_reg        <= 8'd0;
        end else if (fire) begin
            measuring_reg     <= measuring_next;
            wake_count_reg    <= wake_count_next;
            min_co2_reg       <= min_co2_next;
            mark_reg          <= mark_next;
            stored_charge_reg <= stored_charge_next;
            seen_a_reg        <= seen_a_next;
            seen_b_reg        <= seen_b_next;
        end
    end

endmodule

// ===== design/co2_sensor_wake_controller.sv =====
// Top level of the CO2 sensor wake controller: channels, configuration and pipeline registers.
//
// Each wake event of the sensor node enters as one item on the s_ channel and
// gives exactly one result item on the m_ channel, in order. The event kind
// travels in s_tuser and the action taken comes back in m_tuser.
// An accepted item is held in an input register; once the output register
// is free, the decision logic reads it together with the node state, updates
// that state and loads the output register, which drives m_tvalid. While the
// receiver does not stall, one item is taken every cycle, set by the single state
// update per item in the decision stage.
// When the receiver stalls, the result waits in the output register and one
// further item waits in the input register; s_tready then falls.
// Configuration registers are written through cfg_we, cfg_idx and cfg_wdata
// and should only be changed while no item is in flight.
// Reset clears the valid flags of both pipeline registers, returns the node
// state to its reset values and loads the default configuration.
module co2_sensor_wake_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // button_pressed, charge_level, co2_ppm, temperature_code
    input  logic [39:0]                       s_tdata,
    // cmd
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // sleep_seconds, wake_on_sensor, supply_off, report_valid, charge_byte,
    // co2_byte, temperature_byte, status_byte, calib_min_level, calib_clean_level
    output logic [79:0]                       m_tdata,
    // action
    output logic [2:0]                        m_tuser,
    input  logic                              cfg_we,
    input  logic [c2w_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [c2w_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    c2w_pkg::cfg_t    cfg_reg;
    c2w_pkg::item_t   s1_item_reg;
    logic             s1_valid_reg;
    c2w_pkg::result_t m_res_reg;
    logic             m_valid_reg;
    c2w_pkg::result_t res;
    logic             out_free;
    logic             fire;
    logic             s_accept;

    assign out_free = !m_valid_reg || m_tready;
    assign fire     = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sleep_period     <= c2w_pkg::RST_SLEEP_PERIOD;
            cfg_reg.cycle_min        <= c2w_pkg::RST_CYCLE_MIN;
            cfg_reg.cycle_max        <= c2w_pkg::RST_CYCLE_MAX;
            cfg_reg.low_charge_limit <= c2w_pkg::RST_LOW_CHARGE_LIMIT;
            cfg_reg.clean_level      <= c2w_pkg::RST_CLEAN_LEVEL;
            cfg_reg.supply_mode      <= c2w_pkg::RST_SUPPLY_MODE;
        end else if (cfg_we) begin
            unique case (c2w_pkg::reg_idx_t'(cfg_idx))
                c2w_pkg::REG_SLEEP_PERIOD:     cfg_reg.sleep_period     <= cfg_wdata;
                c2w_pkg::REG_CYCLE_MIN:        cfg_reg.cycle_min        <= cfg_wdata[7:0];
                c2w_pkg::REG_CYCLE_MAX:        cfg_reg.cycle_max        <= cfg_wdata[7:0];
                c2w_pkg::REG_LOW_CHARGE_LIMIT: cfg_reg.low_charge_limit <= cfg_wdata[7:0];
                c2w_pkg::REG_CLEAN_LEVEL:      cfg_reg.clean_level      <= cfg_wdata[11:0];
                c2w_pkg::REG_SUPPLY_MODE:      cfg_reg.supply_mode      <= cfg_wdata[1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_item_reg.cmd              <= c2w_pkg::cmd_t'(s_tuser);
            s1_item_reg.button_pressed   <= s_tdata[0];
            s1_item_reg.charge_level     <= s_tdata[8:1];
            s1_item_reg.co2_ppm          <= s_tdata[24:9];
            s1_item_reg.temperature_code <= s_tdata[32:25];
        end
        if (fire) begin
            m_res_reg <= res;
        end
    end

    c2w_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (s1_item_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.action;
    assign m_tdata  = {1'b0,
                       m_res_reg.calib_clean_level,
                       m_res_reg.calib_min_level,
                       m_res_reg.status_byte,
                       m_res_reg.temperature_byte,
                       m_res_reg.co2_byte,
                       m_res_reg.charge_byte,
                       m_res_reg.report_valid,
                       m_res_reg.supply_off,
                       m_res_reg.wake_on_sensor,
                       m_res_reg.sleep_seconds};

    a_result_from_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s1_valid_reg))
        else $error("Result appeared without an item in the decision stage.");

    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> s1_valid_reg)
        else $error("Accepted item was not captured in the input register.");

    a_report_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == c2w_pkg::ACT_REPORT) |->
            (m_res_reg.report_valid && m_res_reg.status_byte == c2w_pkg::STATUS_DATA))
        else $error("Report result without data status.");

    a_calib_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == c2w_pkg::ACT_CALIBRATE) |->
            (m_res_reg.report_valid && m_res_reg.status_byte == c2w_pkg::STATUS_CALIB))
        else $error("Calibration result without calibration status.");

endmodule

// ===== tb/sv/co2_sensor_wake_controller_tb.sv =====
// Self-checking testbench for the CO2 sensor wake controller, with its own model of each wake event.
module co2_sensor_wake_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_t;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RX_HOLD_CYCLES = 60;
    localparam int PHASE_ITEMS    = 90;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [c2w_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [c2w_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    co2_sensor_wake_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    c2w_pkg::cfg_t settings;
    logic        measuring;
    logic [15:0] wake_count;
    logic [15:0] min_co2;
    logic        off_mark;
    logic [7:0]  stored_charge;
    logic [7:0]  seen_cycle_a;
    logic [7:0]  seen_cycle_b;

    c2w_pkg::result_t expected_outcomes[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          tx_gaps = 1'b0;
    int          burst_left = 0;
    rx_style_t   rx_style = RX_ALWAYS;
    int          hold_requests = 0;
    int          holds_served = 0;
    int          hold_left = 0;
    int          rx_phase = 0;

    function automatic void reset_node_state();
        measuring     = 1'b0;
        wake_count    = '0;
        min_co2       = 16'(c2w_pkg::MIN_CO2_RESET);
        off_mark      = 1'b0;
        stored_charge = '0;
        seen_cycle_a  = '0;
        seen_cycle_b  = '0;
    endfunction

    function automatic c2w_pkg::result_t wake_outcome(c2w_pkg::item_t ev);
        c2w_pkg::result_t r;
        int unsigned interval;
        int unsigned calib_wakes;
        int unsigned clean;
        int unsigned mode;
        logic        low;
        r = '0;
        low = 1'b0;
        interval = (settings.sleep_period == 16'd0 ||
                    settings.sleep_period == c2w_pkg::INTERVAL_ALL_ONES) ?
                   c2w_pkg::DEFAULT_INTERVAL : settings.sleep_period;
        calib_wakes = (settings.cycle_min == c2w_pkg::CYCLE_ALL_ONES &&
                       settings.cycle_max == c2w_pkg::CYCLE_ALL_ONES) ?
                      c2w_pkg::DEFAULT_CALIB_WAKES : settings.cycle_min * settings.cycle_max;
        clean = settings.clean_level > c2w_pkg::MAX_LEVEL ?
                c2w_pkg::MAX_LEVEL : settings.clean_level;
        mode = settings.supply_mode == c2w_pkg::MODE_RESERVED ?
               c2w_pkg::MODE_ON : settings.supply_mode;
        case (ev.cmd)
            c2w_pkg::CMD_LEARN: begin
                if (ev.button_pressed) r.action = c2w_pkg::ACT_LEARN;
                else r.action = c2w_pkg::ACT_SLEEP;
            end
            c2w_pkg::CMD_RESET: begin
                reset_node_state();
                r.sleep_seconds = 16'(interval);
            end
            c2w_pkg::CMD_TICK: begin
                if (seen_cycle_a != settings.cycle_min || seen_cycle_b != settings.cycle_max) begin
                    seen_cycle_a = settings.cycle_min;
                    seen_cycle_b = settings.cycle_max;
                    wake_count = '0;
                end
                if (!measuring) begin
                    wake_count = wake_count + 16'd1;
                    stored_charge = ev.charge_level;
                    if (mode != c2w_pkg::MODE_OFF || settings.low_charge_limit != 8'd0) begin
                        if (ev.charge_level <= settings.low_charge_limit) begin
                            low = 1'b1;
                            if (mode == c2w_pkg::MODE_FOLLOW) off_mark = 1'b1;
                        end else begin
                            off_mark = 1'b0;
                        end
                    end
                    if (low) begin
                        r.action = c2w_pkg::ACT_LOW_ENERGY;
                        r.sleep_seconds = 16'(interval);
                    end else if ((seen_cycle_a != 0 && seen_cycle_b != 0 &&
                                  wake_count >= calib_wakes) || ev.button_pressed) begin
                        wake_count = '0;
                        r.action = c2w_pkg::ACT_CALIBRATE;
                        r.report_valid = 1'b1;
                        r.calib_min_level = min_co2;
                        r.calib_clean_level = 12'(clean);
                        r.charge_byte = stored_charge;
                        r.co2_byte = 8'(min_co2 / 10);
                        r.status_byte = c2w_pkg::STATUS_CALIB;
                        min_co2 = 16'(c2w_pkg::MIN_CO2_RESET);
                    end else begin
                        measuring = 1'b1;
                        r.action = c2w_pkg::ACT_MEASURE;
                        r.sleep_seconds = c2w_pkg::SENSOR_WAIT;
                        r.wake_on_sensor = 1'b1;
                    end
                end else begin
                    measuring = 1'b0;
                    r.action = c2w_pkg::ACT_TIMEOUT;
                    r.sleep_seconds = 16'(interval);
                end
            end
            default: begin
                if (ev.co2_ppm < min_co2 && ev.co2_ppm != 16'd0) min_co2 = ev.co2_ppm;
                r.action = c2w_pkg::ACT_REPORT;
                r.report_valid = 1'b1;
                r.charge_byte = stored_charge;
                r.co2_byte = ev.co2_ppm > c2w_pkg::MAX_LEVEL ?
                             c2w_pkg::CO2_SATURATED : 8'(ev.co2_ppm / 10);
                r.temperature_byte = ev.temperature_code;
                r.status_byte = c2w_pkg::STATUS_DATA;
                measuring = 1'b0;
                r.sleep_seconds = 16'(interval);
            end
        endcase
        r.supply_off = (mode == c2w_pkg::MODE_OFF) || off_mark;
        return r;
    endfunction

    function automatic c2w_pkg::item_t make_event(c2w_pkg::cmd_t c, logic pressed,
                                                  logic [7:0] charge, logic [15:0] co2,
                                                  logic [7:0] temp);
        c2w_pkg::item_t ev;
        ev.cmd = c;
        ev.button_pressed = pressed;
        ev.charge_level = charge;
        ev.co2_ppm = co2;
        ev.temperature_code = temp;
        return ev;
    endfunction

    function automatic c2w_pkg::item_t random_event(c2w_pkg::cmd_t c, logic pressed);
        int unsigned pick;
        logic [15:0] co2;
        pick = $urandom_range(0, 9);
        if (pick == 0) co2 = 16'd0;
        else if (pick == 1) co2 = 16'($urandom);
        else if (pick == 2) co2 = 16'($urandom_range(2545, 2560));
        else co2 = 16'($urandom_range(200, 3000));
        return make_event(c, pressed, 8'($urandom), co2, 8'($urandom));
    endfunction

    function automatic c2w_pkg::cfg_t make_settings(logic [15:0] interval, logic [7:0] cmin,
                                                    logic [7:0] cmax, logic [7:0] limit,
                                                    logic [11:0] clean, logic [1:0] mode);
        c2w_pkg::cfg_t c;
        c.sleep_period = interval;
        c.cycle_min = cmin;
        c.cycle_max = cmax;
        c.low_charge_limit = limit;
        c.clean_level = clean;
        c.supply_mode = mode;
        return c;
    endfunction

    function automatic logic [7:0] random_cycle();
        return ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Results are checked against the oldest outstanding prediction.
    always @(posedge aclk) begin
        c2w_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_outcomes.size() == 0) begin
                $error("result item arrived with no prediction outstanding");
                mismatches++;
            end else begin
                want = expected_outcomes.pop_front();
                check_field("action", 16'(want.action), 16'(m_tuser));
                check_field("sleep_seconds", want.sleep_seconds, m_tdata[15:0]);
                check_field("wake_on_sensor", 16'(want.wake_on_sensor), 16'(m_tdata[16]));
                check_field("supply_off", 16'(want.supply_off), 16'(m_tdata[17]));
                check_field("report_valid", 16'(want.report_valid), 16'(m_tdata[18]));
                check_field("charge_byte", 16'(want.charge_byte), 16'(m_tdata[26:19]));
                check_field("co2_byte", 16'(want.co2_byte), 16'(m_tdata[34:27]));
                check_field("temperature_byte", 16'(want.temperature_byte),
                            16'(m_tdata[42:35]));
                check_field("status_byte", 16'(want.status_byte), 16'(m_tdata[50:43]));
                check_field("calib_min_level", want.calib_min_level, m_tdata[66:51]);
                check_field("calib_clean_level", 16'(want.calib_clean_level),
                            16'(m_tdata[78:67]));
            end
        end
    end

    always @(negedge aclk) begin
        bit ready_next;
        ready_next = 1'b1;
        rx_phase <= rx_phase + 1;
        if (hold_left > 0) begin
            ready_next = 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != hold_requests) begin
            ready_next = 1'b0;
            hold_left <= RX_HOLD_CYCLES - 1;
            holds_served <= holds_served + 1;
        end else begin
            case (rx_style)
                RX_RANDOM:  ready_next = $urandom_range(0, 3) != 0;
                RX_PATTERN: ready_next = (rx_phase % 7) < 4;
                default:    ready_next = 1'b1;
            endcase
        end
        m_tready <= ready_next;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_event(c2w_pkg::item_t ev);
        int gap;
        if (tx_gaps) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 16);
                repeat (gap) @(negedge aclk) s_tvalid <= 1'b0;
            end
            burst_left--;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= ev.cmd;
        s_tdata <= {7'd0, ev.temperature_code, ev.co2_ppm, ev.charge_level, ev.button_pressed};
        do @(posedge aclk); while (!s_tready);
        expected_outcomes.push_back(wake_outcome(ev));
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_outcomes.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(c2w_pkg::reg_idx_t idx, logic [15:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            c2w_pkg::REG_SLEEP_PERIOD:     settings.sleep_period = value;
            c2w_pkg::REG_CYCLE_MIN:        settings.cycle_min = value[7:0];
            c2w_pkg::REG_CYCLE_MAX:        settings.cycle_max = value[7:0];
            c2w_pkg::REG_LOW_CHARGE_LIMIT: settings.low_charge_limit = value[7:0];
            c2w_pkg::REG_CLEAN_LEVEL:      settings.clean_level = value[11:0];
            c2w_pkg::REG_SUPPLY_MODE:      settings.supply_mode = value[1:0];
            default: ;
        endcase
    endtask

    task automatic configure(c2w_pkg::cfg_t c);
        drain_results();
        write_reg(c2w_pkg::REG_SLEEP_PERIOD, c.sleep_period);
        write_reg(c2w_pkg::REG_CYCLE_MIN, 16'(c.cycle_min));
        write_reg(c2w_pkg::REG_CYCLE_MAX, 16'(c.cycle_max));
        write_reg(c2w_pkg::REG_LOW_CHARGE_LIMIT, 16'(c.low_charge_limit));
        write_reg(c2w_pkg::REG_CLEAN_LEVEL, 16'(c.clean_level));
        write_reg(c2w_pkg::REG_SUPPLY_MODE, 16'(c.supply_mode));
        @(negedge aclk) cfg_we <= 1'b0;
    endtask

    task automatic test_event_kinds();
        tx_gaps = 1'b0;
        rx_style = RX_ALWAYS;
        send_event(make_event(c2w_pkg::CMD_LEARN, 1'b0, 8'd0, 16'd0, 8'd0));
        send_event(make_event(c2w_pkg::CMD_LEARN, 1'b1, 8'hFF, 16'hFFFF, 8'hFF));
        send_event(make_event(c2w_pkg::CMD_SENSOR, 1'b0, 8'd0, 16'd0, 8'd0));
        send_event(make_event(c2w_pkg::CMD_SENSOR, 1'b1, 8'hFF, 16'd2550, 8'hFF));
        send_event(make_event(c2w_pkg::CMD_SENSOR, 1'b0, 8'd7, 16'd2551, 8'd12));
        send_event(make_event(c2w_pkg::CMD_SENSOR, 1'b0, 8'd9, 16'hFFFF, 8'd99));
        send_event(make_event(c2w_pkg::CMD_SENSOR, 1'b0, 8'd1, 16'd1, 8'd20));
        send_event(make_event(c2w_pkg::CMD_TICK, 1'b0, 8'd1, 16'd500, 8'd3));
        send_event(make_event(c2w_pkg::CMD_TICK, 1'b0, 8'd0, 16'd0, 8'd0));
        send_event(make_event(c2w_pkg::CMD_TICK, 1'b0, 8'd200, 16'd800, 8'd5));
        send_event(make_event(c2w_pkg::CMD_TICK, 1'b0, 8'd150, 16'd0, 8'd0));
        send_event(make_event(c2w_pkg::CMD_TICK, 1'b1, 8'hFF, 16'hFFFF, 8'hFF));
        send_event(make_event(c2w_pkg::CMD_TICK, 1'b0, 8'd120, 16'd0, 8'd0));
        send_event(make_event(c2w_pkg::CMD_SENSOR, 1'b0, 8'd0, 16'd400, 8'd77));
        send_event(make_event(c2w_pkg::CMD_RESET, 1'b1, 8'hAA, 16'h5555, 8'h55));
        send_event(make_event(c2w_pkg::CMD_TICK, 1'b1, 8'd180, 16'd0, 8'd0));
        drain_results();
    endtask

    task automatic test_supply_and_limits();
        configure(make_settings(16'd0, 8'd255, 8'd255, 8'd100, 12'hFFF, 2'd1));
        send_event(make_event(c2w_pkg::CMD_TICK, 1'b0, 8'd50, 16'd0, 8'd0));
        send_event(make_event(c2w_pkg::CMD_SENSOR, 1'b0, 8'd0, 16'd600, 8'd40));
        send_event(make_event(c2w_pkg::CMD_TICK, 1'b0, 8'd150, 16'd0, 8'd0));
        send_event(make_event(c2w_pkg::CMD_TICK, 1'b1, 8'd160, 16'd0, 8'd0));
        send_event(make_event(c2w_pkg::CMD_TICK, 1'b1, 8'd170, 16'd0, 8'd0));
        configure(make_settings(16'hFFFF, 8'd255, 8'd255, 8'd0, 12'd2550, 2'd0));
        send_event(make_event(c2w_pkg::CMD_TICK, 1'b0, 8'd0, 16'd0, 8'd0));
        send_event(make_event(c2w_pkg::CMD_SENSOR, 1'b0, 8'd0, 16'd2000, 8'd1));
        configure(make_settings(16'd1, 8'd255, 8'd255, 8'd255, 12'd0, 2'd3));
        send_event(make_event(c2w_pkg::CMD_TICK, 1'b0, 8'd255, 16'd0, 8'd0));
        send_event(make_event(c2w_pkg::CMD_TICK, 1'b1, 8'd255, 16'd0, 8'd0));
        configure(make_settings(16'd65534, 8'd255, 8'd255, 8'd5, 12'd2551, 2'd0));
        send_event(make_event(c2w_pkg::CMD_TICK, 1'b0, 8'd3, 16'd0, 8'd0));
        send_event(make_event(c2w_pkg::CMD_TICK, 1'b1, 8'd6, 16'd0, 8'd0));
        drain_results();
    endtask

    task automatic measure_rounds(int rounds);
        repeat (rounds) begin
            send_event(make_event(c2w_pkg::CMD_TICK, 1'b0, 8'($urandom_range(10, 200)),
                                  16'd0, 8'd0));
            send_event(random_event(c2w_pkg::CMD_SENSOR, 1'b0));
        end
    endtask

    task automatic test_periodic_calibration();
        tx_gaps = 1'b1;
        rx_style = RX_RANDOM;
        configure(make_settings(16'd600, 8'd2, 8'd3, 8'd0, 12'd1234, 2'd2));
        measure_rounds(14);
        configure(make_settings(16'd900, 8'd2, 8'd1, 8'd0, 12'd400, 2'd2));
        measure_rounds(6);
        configure(make_settings(16'd900, 8'd0, 8'd1, 8'd0, 12'd400, 2'd2));
        measure_rounds(4);
        drain_results();
    endtask

    task automatic test_backpressure();
        configure(make_settings(16'd300, 8'd1, 8'd4, 8'd10, 12'd450, 2'd1));
        tx_gaps = 1'b0;
        rx_style = RX_PATTERN;
        hold_requests++;
        measure_rounds(12);
        drain_results();
    endtask

    task automatic test_random_traffic();
        c2w_pkg::cfg_t c;
        int   sent;
        int   pick;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: c = make_settings(16'd1, 8'd0, 8'd0, 8'd0, 12'd0, 2'd0);
                1: c = make_settings(16'd65534, 8'd255, 8'd255, 8'd255, 12'd2550, 2'd2);
                2: c = make_settings(16'hFFFF, 8'd1, 8'd1, 8'd30, 12'hFFF, 2'd3);
                default: c = make_settings(16'($urandom), random_cycle(), random_cycle(),
                                           8'($urandom_range(0, 60)),
                                           12'($urandom), 2'($urandom));
            endcase
            configure(c);
            tx_gaps = phase != 1;
            rx_style = rx_style_t'(phase % 3);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    send_event(random_event(c2w_pkg::CMD_TICK, 1'b0));
                    send_event(random_event(c2w_pkg::CMD_SENSOR, 1'($urandom)));
                    sent += 2;
                end else if (pick < 65) begin
                    send_event(random_event(c2w_pkg::CMD_TICK, 1'b0));
                    send_event(random_event(c2w_pkg::CMD_TICK, 1'($urandom)));
                    sent += 2;
                end else if (pick < 75) begin
                    send_event(random_event(c2w_pkg::CMD_SENSOR, 1'($urandom)));
                    sent++;
                end else if (pick < 85) begin
                    send_event(random_event(c2w_pkg::CMD_LEARN, 1'($urandom)));
                    sent++;
                end else if (pick < 93) begin
                    send_event(random_event(c2w_pkg::CMD_TICK, 1'b1));
                    sent++;
                end else begin
                    send_event(random_event(c2w_pkg::CMD_RESET, 1'($urandom)));
                    sent++;
                end
                if ($urandom_range(0, 39) == 0) drain_results();
            end
        end
        drain_results();
    endtask

    initial begin
        settings = make_settings(c2w_pkg::RST_SLEEP_PERIOD, c2w_pkg::RST_CYCLE_MIN,
                                 c2w_pkg::RST_CYCLE_MAX, c2w_pkg::RST_LOW_CHARGE_LIMIT,
                                 c2w_pkg::RST_CLEAN_LEVEL, c2w_pkg::RST_SUPPLY_MODE);
        reset_node_state();
        repeat (2) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        test_event_kinds();
        test_supply_and_limits();
        test_periodic_calibration();
        test_backpressure();
        test_random_traffic();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && expected_outcomes.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/c2w_pkg.sv
design/c2w_core.sv
design/co2_sensor_wake_controller.sv
tb/sv/co2_sensor_wake_controller_tb.sv
